// ===== rtl/srr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants of the reorder receiver
// Field widths, sequence space, state encoding and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srr_pkg;

    // Sequence space and payload limit.
    localparam int SEQ_SPACE   = 32;
    localparam int MAX_PAYLOAD = 256;

    // Fixed field widths of the frame and result beats.
    localparam int SEQ_W = 5;
    localparam int LEN_W = 9;

    // Index width of the per-sequence storage.
    localparam int IDX_W = $clog2(SEQ_SPACE);

    // Result kinds.
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_FIRST,
        ST_REL
    } srr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // a frame beat is taken this cycle
        logic load_ack;    // load the acknowledgement into the output register
        logic load_first;  // load the release of the captured frame
        logic load_rel;    // load the release of the held frame at the base
    } srr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic hit;         // captured frame matched the expected base
        logic next_held;   // the sequence after the base is held
        logic cur_held;    // the sequence at the base is held
    } srr_status_t;

endpackage
`default_nettype wire

// ===== rtl/srr_frame_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_frame_if: received frame header channel
// Valid/ready channel carrying one frame header per beat.
// ----------------------------------------------------------------------------
interface srr_frame_if
    import srr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] frame_seq;
    logic [LEN_W-1:0] frame_len;

    modport source (output valid, output frame_seq, output frame_len, input ready);
    modport sink   (input valid, input frame_seq, input frame_len, output ready);
endinterface
`default_nettype wire

// ===== rtl/srr_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_result_if: acknowledgement and release channel
// Valid/ready channel carrying one ack or release descriptor per beat.
// ----------------------------------------------------------------------------
interface srr_result_if
    import srr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [SEQ_W-1:0] out_seq;
    logic [LEN_W-1:0] out_len;
    logic             last;

    modport source (output valid, output kind, output out_seq, output out_len,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_seq, input out_len,
                    input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/srr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Read data holds while no
// read is requested.
// ----------------------------------------------------------------------------
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/srr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ctrl: reorder receiver controller
// Sequences one frame: accept, acknowledge, release the frame itself when it
// matches the base, then release held frames one per beat.
// ----------------------------------------------------------------------------
module srr_ctrl
    import srr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire srr_status_t status,
    output      srr_cmd_t    cmd
);

    srr_state_t state_reg;
    srr_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.load_ack   = 1'b0;
        cmd.load_first = 1'b0;
        cmd.load_rel   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (status.out_free)
                begin
                    cmd.load_ack = 1'b1;
                    state_next   = status.hit ? ST_FIRST : ST_IDLE;
                end
            end
            ST_FIRST:
            begin
                if (status.out_free)
                begin
                    cmd.load_first = 1'b1;
                    state_next     = status.next_held ? ST_REL : ST_IDLE;
                end
            end
            ST_REL:
            begin
                if (status.out_free)
                begin
                    cmd.load_rel = 1'b1;
                    state_next   = status.next_held ? ST_REL : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A release from the chain only happens for a sequence that is held.
    a_rel_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REL) |-> status.cur_held)
        else $error("release chain reached an unheld sequence");

    // Leaving the acknowledge state toward a release requires a base match.
    a_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIRST) |-> status.hit)
        else $error("first release without a base match");

endmodule
`default_nettype wire

// ===== rtl/srr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_datapath: reorder receiver datapath
// Captured frame, expected base, held marks, held length RAM and the output
// register that drives the result channel.
// ----------------------------------------------------------------------------
module srr_datapath
    import srr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire srr_cmd_t         cmd,
    output      srr_status_t      status,
    input  wire logic [SEQ_W-1:0] frame_seq,
    input  wire logic [LEN_W-1:0] frame_len,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic             out_kind,
    output      logic [SEQ_W-1:0] out_seq,
    output      logic [LEN_W-1:0] out_len,
    output      logic             out_last
);

    // Captured frame.
    logic [SEQ_W-1:0] seq_reg;
    logic [LEN_W-1:0] len_reg;
    logic             hit_reg;

    // Reorder state.
    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] base_next;
    logic             held_mark_reg [SEQ_SPACE];

    // Output register.
    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [SEQ_W-1:0] out_seq_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_last_reg;

    logic             in_space;
    logic             in_hit;
    logic             hold_we;
    logic [IDX_W-1:0] in_idx;
    logic [LEN_W-1:0] len_sat;
    logic             rel_load;
    logic             any_load;
    logic [LEN_W-1:0] ram_rdata;

    // Frame decode: range check, base match and length saturation.
    assign in_space = (int'(frame_seq) < SEQ_SPACE);
    assign in_idx   = IDX_W'(frame_seq);
    assign in_hit   = in_space && (int'(frame_seq) == int'(base_reg));
    assign hold_we  = cmd.accept && in_space && !in_hit;
    assign len_sat  = (int'(frame_len) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : frame_len;

    // Base successor, wrapping at the end of the sequence space.
    assign base_next = (base_reg == IDX_W'(SEQ_SPACE - 1)) ? '0 : base_reg + 1'b1;

    assign rel_load = cmd.load_first || cmd.load_rel;
    assign any_load = rel_load || cmd.load_ack;

    // Status toward the controller.
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.hit       = hit_reg;
    assign status.next_held = held_mark_reg[base_next];
    assign status.cur_held  = held_mark_reg[base_reg];

    // Capture the accepted frame.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            seq_reg <= frame_seq;
            len_reg <= len_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            hit_reg <= in_hit;
        end
    end

    // Expected base advances on every release.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (rel_load)
        begin
            base_reg <= base_next;
        end
    end

    // Held marks: set on an out-of-order frame, cleared on release.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEQ_SPACE; i++)
            begin
                held_mark_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (hold_we)
            begin
                held_mark_reg[in_idx] <= 1'b1;
            end
            if (rel_load)
            begin
                held_mark_reg[base_reg] <= 1'b0;
            end
        end
    end

    // Held lengths; the next release's length is read as the base advances.
    srr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SEQ_SPACE)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (hold_we),
        .wr_addr (in_idx),
        .wr_data (len_sat),
        .rd_en   (rel_load),
        .rd_addr (base_next),
        .rd_data (ram_rdata)
    );

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (any_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_ack)
        begin
            out_kind_reg <= KIND_ACK;
            out_seq_reg  <= seq_reg;
            out_len_reg  <= '0;
            out_last_reg <= !hit_reg;
        end
        else if (cmd.load_first)
        begin
            out_kind_reg <= KIND_RELEASE;
            out_seq_reg  <= seq_reg;
            out_len_reg  <= len_reg;
            out_last_reg <= !status.next_held;
        end
        else if (cmd.load_rel)
        begin
            out_kind_reg <= KIND_RELEASE;
            out_seq_reg  <= SEQ_W'(base_reg);
            out_len_reg  <= ram_rdata;
            out_last_reg <= !status.next_held;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_seq   = out_seq_reg;
    assign out_len   = out_len_reg;
    assign out_last  = out_last_reg;

    // A new beat never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        any_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

    // The base only moves as a result of a release.
    a_base_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(base_reg) |-> $past(rel_load))
        else $error("expected base moved without a release");

    // A held frame leaves its mark set.
    a_hold_mark: assert property (@(posedge clk) disable iff (!rst_n)
        hold_we |=> held_mark_reg[$past(in_idx)])
        else $error("held mark not set after an out-of-order frame");

endmodule
`default_nettype wire

// ===== rtl/selective_repeat_reorder_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_reorder_receiver: selective-repeat ARQ reorder tracker
//
// The frame channel takes one received frame header per beat (sequence
// number and payload length). For each frame the result channel first gives
// an acknowledgement beat, then, when the frame matches the expected base,
// a release beat for the frame and one release beat for each consecutively
// held frame after it. The final beat of a frame carries last. Frames that
// do not match the base are held: their length is stored and they are
// released later, in order. Lengths above the payload limit are saturated.
//
// Timing: a frame is taken in the idle state and its ack is loaded from the
// acknowledge state once the output register is free. A held frame passes
// idle and acknowledge; a matching frame also passes the first-release state
// and one release state per chained release. The release chain is set by
// one held-length RAM read per cycle while the output register is free. The
// block takes a new frame while the last result beat waits in that register.
//
// Reset clears the held marks and sets the expected base to zero. When the
// result receiver stalls, the output register holds its beat and the
// controller waits; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_receiver
    import srr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    srr_frame_if.sink  frame,
    srr_result_if.source result
);

    srr_cmd_t    cmd;
    srr_status_t status;

    // Controller.
    srr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frame.valid),
        .in_ready (frame.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    srr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .frame_seq (frame.frame_seq),
        .frame_len (frame.frame_len),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_kind  (result.kind),
        .out_seq   (result.out_seq),
        .out_len   (result.out_len),
        .out_last  (result.last)
    );

endmodule
`default_nettype wire

// ===== verif/selective_repeat_reorder_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_reorder_receiver_tb: reorder receiver testbench
// Sends frame headers and checks every ack and release beat. The expected
// beats come from a behavioral tracker of held marks, held lengths and the
// expected base. Stimulus starts with a few directed frames, then uses
// shuffled windows of consecutive sequence numbers from the current base,
// mixed with drops, duplicates and stray frames. Both channels stall at
// random, and there is one long stall on the result side.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_receiver_tb;
    import srr_pkg::*;

    localparam int ITEM_TARGET  = 320;
    localparam int CALM_ITEMS   = 40;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } frame_hdr_t;

    typedef struct packed {
        logic             kind;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic             last;
    } result_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    srr_frame_if  frame_ch ();
    srr_result_if result_ch ();

    selective_repeat_reorder_receiver uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    // Tracker state of the receiver.
    logic             held_flag  [SEQ_SPACE];
    logic [LEN_W-1:0] held_bytes [SEQ_SPACE];
    logic [SEQ_W-1:0] next_base;

    frame_hdr_t   frames_to_send [$];
    result_beat_t expected_beats [$];

    int sent_count     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_gap         = 0;
    int rx_gap         = 0;
    int hold_left      = 0;
    bit calm           = 1'b0;
    bit frame_taken    = 1'b0;

    always #1 clk = ~clk;

    // Work out the beats that one accepted frame causes.
    task automatic predict_frame(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len);
        result_beat_t beat;
        logic [LEN_W-1:0] clipped;
        clipped = len;
        if (len > MAX_PAYLOAD)
            clipped = LEN_W'(MAX_PAYLOAD);
        beat.kind = KIND_ACK;
        beat.seq  = seq;
        beat.len  = '0;
        // The sequence field cannot leave the sequence space, so every frame
        // is either released or held.
        if (seq != next_base)
        begin
            beat.last = 1'b1;
            expected_beats.push_back(beat);
            held_bytes[seq] = clipped;
            held_flag[seq]  = 1'b1;
        end
        else
        begin
            beat.last = 1'b0;
            expected_beats.push_back(beat);
            held_flag[seq] = 1'b0;
            beat.kind = KIND_RELEASE;
            beat.len  = clipped;
            next_base = SEQ_W'((next_base + 1) % SEQ_SPACE);
            // Drain the chain of held frames that now follow the base.
            while (held_flag[next_base])
            begin
                expected_beats.push_back(beat);
                beat.seq  = next_base;
                beat.len  = held_bytes[next_base];
                held_flag[next_base] = 1'b0;
                next_base = SEQ_W'((next_base + 1) % SEQ_SPACE);
            end
            beat.last = 1'b1;
            expected_beats.push_back(beat);
        end
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LEN_W'(MAX_PAYLOAD);
            2:       return LEN_W'($urandom_range(MAX_PAYLOAD + 1, (1 << LEN_W) - 1));
            default: return LEN_W'($urandom_range(0, MAX_PAYLOAD));
        endcase
    endfunction

    task automatic queue_frame(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len);
        frame_hdr_t hdr;
        hdr.seq = seq;
        hdr.len = len;
        frames_to_send.push_back(hdr);
        sent_count++;
    endtask

    // Wait until every queued frame has been taken, so the base is current.
    task automatic wait_frames_taken();
        @(posedge clk);
        while (frames_to_send.size() != 0 || frame_ch.valid)
            @(posedge clk);
    endtask

    task automatic wait_results_done();
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // Shuffled window of consecutive sequence numbers starting at the base,
    // sometimes with the base held back to the end so the whole window drains
    // at once, and sometimes broken by a drop, a duplicate or a stray frame.
    task automatic queue_window(input int span, input bit base_last);
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] seq_at;
        int               pick;
        int               top;
        for (int i = 0; i < span; i++)
        begin
            seq_at = SEQ_W'(next_base + i);
            order.push_back(seq_at);
        end
        if (base_last)
            order.push_back(order.pop_front());
        top = base_last ? order.size() - 2 : order.size() - 1;
        for (int i = top; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            seq_at = order[i];
            order[i] = order[pick];
            order[pick] = seq_at;
        end
        case ($urandom_range(0, 7))
            0:
            begin
                if (order.size() > 1)
                    order.delete($urandom_range(0, order.size() - 1));
            end
            1:       order.insert($urandom_range(0, order.size()),
                                  order[$urandom_range(0, order.size() - 1)]);
            2:       order.insert($urandom_range(0, order.size()),
                                  SEQ_W'($urandom_range(0, SEQ_SPACE - 1)));
            default: ;
        endcase
        foreach (order[i])
            queue_frame(order[i], pick_len());
    endtask

    // Frame driver: holds a beat until it is taken, then idles or moves on.
    always @(negedge clk)
    begin : drive_frames
        frame_hdr_t hdr;
        if (rst_n)
        begin
            if (!frame_ch.valid || frame_taken)
            begin
                frame_taken = 1'b0;
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    frame_ch.valid <= 1'b0;
                end
                else if (frames_to_send.size() != 0)
                begin
                    hdr = frames_to_send.pop_front();
                    frame_ch.valid     <= 1'b1;
                    frame_ch.frame_seq <= hdr.seq;
                    frame_ch.frame_len <= hdr.len;
                    if (!calm && $urandom_range(0, 7) == 0)
                        tx_gap = $urandom_range(1, 10);
                end
                else
                begin
                    frame_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Update the tracker on every frame beat the block takes.
    always @(posedge clk)
    begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            predict_frame(frame_ch.frame_seq, frame_ch.frame_len);
            frame_taken = 1'b1;
        end
    end

    // Result ready: long hold-off when asked, otherwise random stall bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    rx_gap = $urandom_range(1, 10);
            end
        end
    end

    // Compare each result beat with the oldest expected beat.
    always @(posedge clk)
    begin : check_results
        result_beat_t got;
        result_beat_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.kind = result_ch.kind;
            got.seq  = result_ch.out_seq;
            got.len  = result_ch.out_len;
            got.last = result_ch.last;
            if (expected_beats.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected beat: kind=%0d seq=%0d len=%0d last=%0d",
                             got.kind, got.seq, got.len, got.last);
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                        $display({"beat mismatch: expected kind=%0d seq=%0d len=%0d last=%0d,",
                                  " got kind=%0d seq=%0d len=%0d last=%0d"},
                                 want.kind, want.seq, want.len, want.last,
                                 got.kind, got.seq, got.len, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("selective_repeat_reorder_receiver verification failed");
        $finish;
    end

    initial
    begin
        frame_ch.valid     = 1'b0;
        frame_ch.frame_seq = '0;
        frame_ch.frame_len = '0;
        result_ch.ready    = 1'b0;
        foreach (held_flag[i])
        begin
            held_flag[i]  = 1'b0;
            held_bytes[i] = '0;
        end
        next_base = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // In-order frames with length extremes and saturation.
        queue_frame(0, 0);
        queue_frame(1, 511);
        queue_frame(2, 257);
        queue_frame(3, 256);
        // Held frames, a duplicate that overwrites, then a short chain.
        queue_frame(5, 100);
        queue_frame(5, 200);
        queue_frame(31, 9'h155);
        queue_frame(6, 9'h0AA);
        queue_frame(4, 4);
        // A stale frame behind the base waits for the wrap.
        queue_frame(2, 85);
        queue_frame(30, 1);
        queue_frame(7, 0);

        // Full window released at once while results are held off.
        wait_frames_taken();
        hold_left = LONG_HOLD;
        queue_window(SEQ_SPACE, 1'b1);

        while (sent_count < ITEM_TARGET - CALM_ITEMS)
        begin
            wait_frames_taken();
            queue_window(($urandom_range(0, 9) == 0) ? SEQ_SPACE : $urandom_range(1, 8),
                         1'($urandom_range(0, 1)));
        end

        // Let everything drain, then finish with no idling on either side.
        wait_frames_taken();
        wait_results_done();
        calm = 1'b1;
        while (sent_count < ITEM_TARGET)
        begin
            wait_frames_taken();
            queue_window($urandom_range(1, 8), 1'($urandom_range(0, 1)));
        end

        wait_frames_taken();
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("selective_repeat_reorder_receiver verification clean");
        else
            $display("selective_repeat_reorder_receiver verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/srr_pkg.sv
rtl/srr_frame_if.sv
rtl/srr_result_if.sv
rtl/srr_ram.sv
rtl/srr_ctrl.sv
rtl/srr_datapath.sv
rtl/selective_repeat_reorder_receiver.sv
verif/selective_repeat_reorder_receiver_tb.sv
